// ----- design/histogram_overlap_rebinner_core_assert.svh -----
// Assertion macros shared by the rebinner modules.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef HISTOGRAM_OVERLAP_REBINNER_CORE_ASSERT_SVH
`define HISTOGRAM_OVERLAP_REBINNER_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HOR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rebinner check failed");

// Check that cons holds in the cycle after ante.
`define HOR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rebinner check failed");

`endif

// ----- design/hor_pkg.sv -----
// Shared types and constants of the histogram rebinner.
// No dependencies.
package hor_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;
  localparam int DATA_W    = 32;
  localparam int WGT_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int SUM_W     = 64;

  localparam logic [1:0] OP_ACC   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_BINS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BINS = 4'd1;

  typedef struct packed {
    logic acc_start;
    logic rd_start;
    logic clr_init;
    logic clr_wr;
    logic pos;
    logic ovl;
    logic div_start;
    logic mul;
    logic sq;
    logic wr;
    logic j_inc;
    logic i_inc;
    logic set_first;
    logic rd_mem;
    logic sqrt_start;
    logic res_load;
    logic res_zero;
  } cmd_t;

  typedef struct packed {
    logic acc_ok;
    logic rd_ok;
    logic j_ok;
    logic hit;
    logic div_done;
    logic sqrt_done;
    logic clr_last;
  } sts_t;

endpackage

// ----- design/histogram_overlap_rebinner_core.sv -----
// Top level of the histogram rebinner: sequencer plus datapath.
// Depends on hor_pkg, hor_ctrl, hor_dp and the assertion macro header.
//
// Use: write in_bins (index 0) and out_bins (index 1) on the config port
// while the core is idle, then issue commands with start. A command beat is
// taken on a rising edge with start high and busy low.
//   op 0 accumulates the next source bin (content, error in Q16.16).
//   op 1 reads output bin read_bin; the result shows on out_* for exactly
//        one cycle with out_valid_o high. The receiver cannot stall it.
//   op 2 clears both sum memories and restarts the scan.
// An accumulate beat works through each output bin it overlaps in turn
// (one weight division of 17 serial steps per bin, then multiply, square
// and read-modify-write of the sum memories), with one more position check
// when the scan runs past the last output bin without closing the source bin.
// A read fetches the sums, then runs the 32-step square root before the
// strobe, and busy is already low while the strobe shows; an out-of-range
// read strobes zeros on the next cycle.
// Reset and op 2 run a clearing pass over all MAX_BINS entries, one memory
// entry a cycle, with busy high; config writes are still taken during it.
module histogram_overlap_rebinner_core import hor_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op_i,
  input  logic signed [DATA_W-1:0] content_i,
  input  logic [DATA_W-1:0]        error_i,
  input  logic [CFG_W-1:0]         read_bin_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic                     out_valid_o,
  output logic signed [DATA_W-1:0] out_content_o,
  output logic [DATA_W-1:0]        out_error_o,
  output logic [CFG_W-1:0]         out_bin_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decode the beat, step through scan, division and root
  hor_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .op_i        (op_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .out_valid_o (out_valid_o)
  );

  // Datapath: hold config, scan pointers, sums and result registers
  hor_dp #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .content_i     (content_i),
    .error_i       (error_i),
    .read_bin_i    (read_bin_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_content_o (out_content_o),
    .out_error_o   (out_error_o),
    .out_bin_o     (out_bin_o)
  );

  `include "histogram_overlap_rebinner_core_assert.svh"

  // A clear beat must hold the core busy while the pass runs
  `HOR_ASSERT_NEXT(a_clear_goes_busy, start && !busy && op_i == OP_CLEAR, busy)
  // A rejected read carries zeros throughout
  `HOR_ASSERT_NOW(a_zero_read, out_valid_o && out_bin_o == '0,
                  out_content_o == '0 && out_error_o == '0)

endmodule

// ----- design/hor_div.sv -----
// Bit-serial divider for the overlap weight floor(ov * 2^16 / den).
// Depends on hor_pkg.
module hor_div import hor_pkg::*; #(
  parameter int BW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BW-1:0]    ov_i,
  input  logic [BW-1:0]    den_i,
  output logic             done_o,
  output logic [WGT_W-1:0] quot_o
);

  logic [BW-1:0]    rem_q;
  logic [WGT_W-1:0] quot_q;
  logic [4:0]       cnt_q;
  logic             run_q, done_q, lsb_q;
  logic [BW:0]      trial, diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, (cnt_q == 5'd0) ? lsb_q : 1'b0};
    diff  = trial - {1'b0, den_i};
    qbit  = (trial >= {1'b0, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 5'(WGT_W - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(WGT_W - 1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= ov_i >> 1;
      lsb_q  <= ov_i[0];
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= qbit ? diff[BW-1:0] : trial[BW-1:0];
      quot_q <= {quot_q[WGT_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- design/hor_sqrt.sv -----
// Iterative integer square root of a 64-bit sum, two bits a cycle.
// Depends on hor_pkg.
module hor_sqrt import hor_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  val_i,
  output logic              done_o,
  output logic [DATA_W-1:0] root_o
);

  logic [SUM_W-1:0] v_q, r_q, bit_q, t;
  logic [4:0]       cnt_q;
  logic             run_q, done_q;

  assign t = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 5'd31);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(SUM_W-2){1'b0}}};
    end else if (run_q) begin
      if (v_q >= t) begin
        v_q <= v_q - t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[DATA_W-1:0];

endmodule

// ----- design/hor_ctrl.sv -----
// Sequencer of the rebinner: accepts commands and steps the datapath.
// Depends on hor_pkg and the assertion macro header.
module hor_ctrl import hor_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       out_valid_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_A_POS, ST_A_OVL, ST_A_DIVS, ST_A_DIVW,
    ST_A_MUL, ST_A_SQ, ST_A_WR, ST_R_MEM, ST_R_SQS, ST_R_SQW
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, valid_q, valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_i)
            OP_ACC: begin
              if (sts_i.acc_ok) begin
                cmd.acc_start = 1'b1;
                state_d       = ST_A_POS;
              end
            end
            OP_READ: begin
              if (sts_i.rd_ok) begin
                cmd.rd_start = 1'b1;
                state_d      = ST_R_MEM;
              end else begin
                cmd.res_zero = 1'b1;
                valid_d      = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd.clr_init = 1'b1;
              state_d      = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_A_POS: begin
        if (sts_i.j_ok) begin
          cmd.pos = 1'b1;
          state_d = ST_A_OVL;
        end else begin
          cmd.i_inc = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_A_OVL: begin
        cmd.ovl = 1'b1;
        state_d = ST_A_DIVS;
      end
      ST_A_DIVS: begin
        cmd.div_start = 1'b1;
        state_d       = ST_A_DIVW;
      end
      ST_A_DIVW: begin
        if (sts_i.div_done) state_d = ST_A_MUL;
      end
      ST_A_MUL: begin
        cmd.mul = 1'b1;
        state_d = ST_A_SQ;
      end
      ST_A_SQ: begin
        cmd.sq  = 1'b1;
        state_d = ST_A_WR;
      end
      ST_A_WR: begin
        cmd.wr = 1'b1;
        if (sts_i.hit) begin
          cmd.set_first = 1'b1;
          cmd.i_inc     = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          cmd.j_inc = 1'b1;
          state_d   = ST_A_POS;
        end
      end
      ST_R_MEM: begin
        cmd.rd_mem = 1'b1;
        state_d    = ST_R_SQS;
      end
      ST_R_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_d        = ST_R_SQW;
      end
      ST_R_SQW: begin
        if (sts_i.sqrt_done) begin
          cmd.res_load = 1'b1;
          valid_d      = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      busy_q  <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
      valid_q <= valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign busy        = busy_q;
  assign out_valid_o = valid_q;

  `include "histogram_overlap_rebinner_core_assert.svh"

  `HOR_ASSERT_NOW(a_div_done_waits, sts_i.div_done, state_q == ST_A_DIVW)
  `HOR_ASSERT_NOW(a_sqrt_done_waits, sts_i.sqrt_done, state_q == ST_R_SQW)

endmodule

// ----- design/hor_dp.sv -----
// Datapath of the rebinner: registers, sum memories, weight and error arithmetic.
// Depends on hor_pkg, hor_div and hor_sqrt.
module hor_dp import hor_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic signed [DATA_W-1:0] content_i,
  input  logic [DATA_W-1:0]        error_i,
  input  logic [CFG_W-1:0]         read_bin_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic signed [DATA_W-1:0] out_content_o,
  output logic [DATA_W-1:0]        out_error_o,
  output logic [CFG_W-1:0]         out_bin_o
);

  localparam int BW = $clog2(MAX_BINS + 1);
  localparam int CW = BW + 1;
  localparam int AW = $clog2(MAX_BINS);
  localparam int PW = 2 * BW;

  function automatic logic [BW-1:0] eff_bins(input logic [CFG_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x == 32'd0) x = 32'd1;
    else if (x > 32'(MAX_BINS)) x = 32'(MAX_BINS);
    return BW'(x);
  endfunction

  logic [CFG_W-1:0] in_bins_q, out_bins_q, rb_q;
  logic [BW-1:0]    ni, no;
  logic [CW-1:0]    i_q, first_q, j_q, jm1;
  logic [AW-1:0]    clr_addr_q, wa, ra;
  logic [31:0]      rbm1;
  logic [PW-1:0]    hi1_q, hi2_q, lo1, lo2, lo, hi;
  logic [BW-1:0]    ov_q;
  logic             hit_q;
  logic signed [DATA_W-1:0] content_q;
  logic [DATA_W-1:0]        error_q, e_q;
  logic signed [49:0]       prod_c_q;
  logic [48:0]              eprod;
  logic [SUM_W-1:0]         sq_q, rd_e_q, new_e;
  logic signed [SUM_W-1:0]  rd_c_q, new_c;
  logic signed [SUM_W:0]    csum;
  logic [SUM_W:0]           esum;
  logic [WGT_W-1:0]         w;
  logic                     div_done, sqrt_done, we, re;
  logic [DATA_W-1:0]        root;
  logic signed [DATA_W-1:0] rd_content;

  logic signed [SUM_W-1:0] csum_mem [MAX_BINS];
  logic [SUM_W-1:0]        esum_mem [MAX_BINS];

  assign ni = eff_bins(in_bins_q);
  assign no = eff_bins(out_bins_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bins_q  <= CFG_W'(1);
      out_bins_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IN_BINS)  in_bins_q  <= cfg_wdata_i;
      if (cfg_idx_i == CFG_OUT_BINS) out_bins_q <= cfg_wdata_i;
    end
  end

  // Scan position control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q        <= CW'(1);
      first_q    <= CW'(1);
      j_q        <= CW'(1);
      clr_addr_q <= '0;
    end else begin
      if (cmd_i.clr_init) begin
        i_q        <= CW'(1);
        first_q    <= CW'(1);
        clr_addr_q <= '0;
      end
      if (cmd_i.clr_wr)    clr_addr_q <= clr_addr_q + AW'(1);
      if (cmd_i.acc_start) j_q <= first_q;
      if (cmd_i.j_inc)     j_q <= j_q + CW'(1);
      if (cmd_i.set_first) first_q <= j_q;
      if (cmd_i.i_inc)     i_q <= i_q + CW'(1);
    end
  end

  // Operand capture and arithmetic stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_start || cmd_i.rd_start) begin
      content_q <= content_i;
      error_q   <= error_i;
      rb_q      <= read_bin_i;
    end
    if (cmd_i.acc_start) hi1_q <= PW'(i_q[BW-1:0]) * PW'(no);
    if (cmd_i.pos)       hi2_q <= PW'(j_q[BW-1:0]) * PW'(ni);
    if (cmd_i.ovl) begin
      ov_q  <= (hi > lo) ? BW'(hi - lo) : '0;
      hit_q <= (hi1_q <= hi2_q);
    end
    if (cmd_i.mul) begin
      prod_c_q <= 50'(content_q) * 50'($signed({1'b0, w}));
      e_q      <= eprod[FRAC_W +: DATA_W];
    end
    if (cmd_i.sq) sq_q <= SUM_W'(e_q) * SUM_W'(e_q);
  end

  always_comb begin
    lo1   = hi1_q - PW'(no);
    lo2   = hi2_q - PW'(ni);
    lo    = (lo1 > lo2) ? lo1 : lo2;
    hi    = (hi1_q < hi2_q) ? hi1_q : hi2_q;
    eprod = 49'(error_q) * 49'(w);
  end

  // Saturating accumulate of the two sums
  always_comb begin
    csum = 65'(rd_c_q) + 65'(prod_c_q);
    if (csum[SUM_W] != csum[SUM_W-1])
      new_c = csum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      new_c = csum[SUM_W-1:0];
    esum  = {1'b0, rd_e_q} + {1'b0, sq_q};
    new_e = esum[SUM_W] ? {SUM_W{1'b1}} : esum[SUM_W-1:0];
  end

  // Memory ports: one write, one registered read
  always_comb begin
    jm1  = j_q - CW'(1);
    rbm1 = 32'(rb_q) - 32'd1;
    we   = cmd_i.clr_wr || cmd_i.wr;
    wa   = cmd_i.clr_wr ? clr_addr_q : jm1[AW-1:0];
    re   = cmd_i.pos || cmd_i.rd_mem;
    ra   = cmd_i.rd_mem ? rbm1[AW-1:0] : jm1[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      csum_mem[wa] <= cmd_i.clr_wr ? '0 : new_c;
      esum_mem[wa] <= cmd_i.clr_wr ? '0 : new_e;
    end
    if (re) begin
      rd_c_q <= csum_mem[ra];
      rd_e_q <= esum_mem[ra];
    end
  end

  hor_div #(.BW(BW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .ov_i    (ov_q),
    .den_i   (no),
    .done_o  (div_done),
    .quot_o  (w)
  );

  hor_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .val_i   (rd_e_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Floor of the Q32.32 sum to Q16.16, clamped to 32 bits
  always_comb begin
    if (rd_c_q[SUM_W-1] && !(&rd_c_q[SUM_W-1:47]))
      rd_content = {1'b1, {(DATA_W-1){1'b0}}};
    else if (!rd_c_q[SUM_W-1] && (|rd_c_q[SUM_W-1:47]))
      rd_content = {1'b0, {(DATA_W-1){1'b1}}};
    else
      rd_content = rd_c_q[47:FRAC_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_zero) begin
      out_content_o <= '0;
      out_error_o   <= '0;
      out_bin_o     <= '0;
    end else if (cmd_i.res_load) begin
      out_content_o <= rd_content;
      out_error_o   <= root;
      out_bin_o     <= rb_q;
    end
  end

  always_comb begin
    sts_o.acc_ok    = (i_q <= {1'b0, ni});
    sts_o.rd_ok     = (read_bin_i != '0) && (32'(read_bin_i) <= 32'(no));
    sts_o.j_ok      = (j_q <= {1'b0, no});
    sts_o.hit       = hit_q;
    sts_o.div_done  = div_done;
    sts_o.sqrt_done = sqrt_done;
    sts_o.clr_last  = (clr_addr_q == AW'(MAX_BINS - 1));
  end

endmodule

// ----- test/tb_histogram_overlap_rebinner_core.sv -----
// Self-checking testbench for histogram_overlap_rebinner_core.
// Depends on hor_pkg and the core; predicts every read beat and compares it.
module tb_histogram_overlap_rebinner_core;
  import hor_pkg::*;

  localparam int          NBINS   = 1024;
  localparam logic [1:0]  OP_NONE = 2'd3;   // unused opcode, must do nothing
  localparam int          WDOG    = 250000;
  localparam int          ITEMS   = 1050;

  typedef struct {
    logic signed [DATA_W-1:0] content;
    logic [DATA_W-1:0]        error;
    logic [CFG_W-1:0]         bin;
  } bin_read_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               op_i;
  logic signed [DATA_W-1:0] content_i;
  logic [DATA_W-1:0]        error_i;
  logic [CFG_W-1:0]         read_bin_i;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_W-1:0]         cfg_wdata_i;
  logic                     out_valid_o;
  logic signed [DATA_W-1:0] out_content_o;
  logic [DATA_W-1:0]        out_error_o;
  logic [CFG_W-1:0]         out_bin_o;

  histogram_overlap_rebinner_core #(.MAX_BINS(NBINS)) uut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .content_i, .error_i, .read_bin_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .out_valid_o, .out_content_o,
    .out_error_o, .out_bin_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: shadow of the sum memories, scan pointers and registers.
  logic [CFG_W-1:0]   src_bins_reg, dst_bins_reg;
  longint signed      content_sum [NBINS];
  logic [SUM_W-1:0]   err_sq_sum  [NBINS];
  int                 next_src, first_dst;
  bin_read_t          pending_reads[$];
  bit                 failed = 0;
  int                 beats_done = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  function automatic int eff_bins(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NBINS) return NBINS;
    return int'(v);
  endfunction

  function automatic logic [SUM_W-1:0] root_floor(logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    foreach (content_sum[k]) begin
      content_sum[k] = 0;
      err_sq_sum[k]  = 0;
    end
    next_src  = 1;
    first_dst = 1;
  endfunction

  // Spread one source bin over the output bins it overlaps.
  function automatic void spread_source_bin(logic signed [DATA_W-1:0] c,
                                            logic [DATA_W-1:0] e);
    longint ni, no, lo1, hi1, lo2, hi2, lo, hi, ov, w;
    logic [SUM_W-1:0] es, sq;
    logic [SUM_W:0]   usum;
    logic signed [SUM_W:0] ssum;
    ni = eff_bins(src_bins_reg);
    no = eff_bins(dst_bins_reg);
    if (next_src < 1 || next_src > ni) return;
    lo1 = (next_src - 1) * no;
    hi1 = next_src * no;
    for (longint j = first_dst; j >= 1 && j <= no; j++) begin
      lo2 = (j - 1) * ni;
      hi2 = j * ni;
      lo  = lo1 > lo2 ? lo1 : lo2;
      hi  = hi1 < hi2 ? hi1 : hi2;
      ov  = hi > lo ? hi - lo : 0;
      w   = (ov * 65536) / no;
      es  = ({32'd0, e} * w) >> 16;
      sq  = es * es;
      ssum = content_sum[j-1] + longint'(c) * w;
      if (ssum > 65'sh0_7FFF_FFFF_FFFF_FFFF)      content_sum[j-1] = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (ssum < -65'sh0_8000_0000_0000_0000) content_sum[j-1] = 64'sh8000_0000_0000_0000;
      else                                          content_sum[j-1] = ssum[63:0];
      usum = {1'b0, err_sq_sum[j-1]} + sq;
      err_sq_sum[j-1] = usum[64] ? '1 : usum[63:0];
      if (hi1 <= hi2) begin
        first_dst = int'(j);
        break;
      end
    end
    next_src++;
  endfunction

  function automatic bin_read_t read_bin_value(logic [CFG_W-1:0] rb);
    bin_read_t r;
    longint v;
    r = '{0, 0, 0};
    if (rb >= 1 && rb <= eff_bins(dst_bins_reg)) begin
      v = content_sum[rb-1] >>> 16;
      if (v > 64'sh7FFF_FFFF)       r.content = 32'sh7FFF_FFFF;
      else if (v < -64'sh8000_0000) r.content = 32'sh8000_0000;
      else                          r.content = v[31:0];
      r.error = DATA_W'(root_floor(err_sq_sum[rb-1]));
      r.bin   = rb;
    end
    return r;
  endfunction

  // Compare every strobed result with the oldest pending read.
  always @(posedge clk_i) begin
    bin_read_t exp_r;
    if (rst_ni && out_valid_o) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result bin %0d content %0h error %0h", $time,
                 out_bin_o, out_content_o, out_error_o);
        failed = 1;
      end else begin
        exp_r = pending_reads.pop_front();
        if (out_content_o !== exp_r.content) begin
          $display("%0t: content expected %0h actual %0h", $time, exp_r.content,
                   out_content_o);
          failed = 1;
        end
        if (out_error_o !== exp_r.error) begin
          $display("%0t: error expected %0h actual %0h", $time, exp_r.error,
                   out_error_o);
          failed = 1;
        end
        if (out_bin_o !== exp_r.bin) begin
          $display("%0t: bin expected %0d actual %0d", $time, exp_r.bin, out_bin_o);
          failed = 1;
        end
      end
    end
  end

  // Watchdog: restart the count whenever a beat moves in either direction.
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one command beat and hold it until taken; the caller sits just
  // after a rising edge. Leave start high inside a burst, drop it between.
  task automatic send_beat(logic [1:0] op, logic signed [DATA_W-1:0] c,
                           logic [DATA_W-1:0] e, logic [CFG_W-1:0] rb);
    bit counted;
    start      <= 1'b1;
    op_i       <= op;
    content_i  <= c;
    error_i    <= e;
    read_bin_i <= rb;
    do @(posedge clk_i); while (busy);
    counted = 1;
    case (op)
      OP_ACC: begin
        counted = next_src <= eff_bins(src_bins_reg);
        spread_source_bin(c, e);
      end
      OP_READ:  pending_reads.push_back(read_bin_value(rb));
      OP_CLEAR: clear_sums();
      default:  counted = 0;
    endcase
    if (counted) beats_done++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
  endtask

  task automatic hold_idle();
    start <= 1'b0;
  endtask

  // Let every pending read drain and the core fall quiet before a write.
  task automatic drain();
    hold_idle();
    @(posedge clk_i);
    while (pending_reads.size() != 0 || busy) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Drive one register write; the caller drops the write enable afterwards.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_IN_BINS) src_bins_reg = val;
    else if (idx == CFG_OUT_BINS) dst_bins_reg = val;
  endtask

  task automatic set_bins(logic [CFG_W-1:0] ni, logic [CFG_W-1:0] no);
    drain();
    write_reg(CFG_IN_BINS, ni);
    write_reg(CFG_OUT_BINS, no);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(0, 32'h3_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // Reset defaults: one source bin onto one output bin.
  task automatic test_reset_defaults();
    send_beat(OP_READ, 0, 0, 11'd1);
    send_beat(OP_ACC, 32'sh0001_8000, 32'h0000_4000, 0);
    send_beat(OP_READ, 0, 0, 11'd1);
  endtask

  // Field extremes across an uneven 3 to 5 mapping, plus range and unused op.
  task automatic test_field_extremes();
    set_bins(11'd3, 11'd5);
    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_ACC, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(OP_ACC, 32'sh8000_0000, 32'h0, 0);
    send_beat(OP_NONE, 32'sh1234_5678, 32'h1, 11'd2);
    send_beat(OP_ACC, -32'sd1, 32'hAAAA_5555, 0);
    send_beat(OP_ACC, 32'sd5, 32'd5, 0);          // beyond in_bins, ignored
    for (int b = 0; b <= 6; b++) send_beat(OP_READ, 0, 0, b[CFG_W-1:0]);
    send_beat(OP_READ, 0, 0, 11'h7FF);
    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_READ, 0, 0, 11'd1);
  endtask

  // Register extremes: zero acts as one, above the maximum acts as the maximum.
  task automatic test_register_extremes();
    set_bins(11'd0, 11'h7FF);
    send_beat(OP_CLEAR, 0, 0, 0);
    send_beat(OP_ACC, 32'sh4000_0000, 32'h8000_0000, 0);
    send_beat(OP_READ, 0, 0, 11'd1024);
    send_beat(OP_READ, 0, 0, 11'd1025);
    set_bins(11'h7FF, 11'd0);
    send_beat(OP_CLEAR, 0, 0, 0);
    repeat (3) send_beat(OP_ACC, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0);
    send_beat(OP_READ, 0, 0, 11'd1);              // saturates the read
  endtask

  // Well-formed passes with random content; some broken and noisy beats.
  task automatic test_random_passes();
    int ni, no, n_acc;
    logic [CFG_W-1:0] rb;
    while (beats_done < ITEMS) begin
      case ($urandom_range(0, 19))
        0:       set_bins(11'd1, 11'd1024);
        1:       set_bins(11'd1024, CFG_W'($urandom_range(1, 9)));
        2:       set_bins(11'd0, 11'h7FF);
        3:       set_bins(CFG_W'($urandom_range(1025, 2047)),
                          CFG_W'($urandom_range(0, 3)));
        default: set_bins(CFG_W'($urandom_range(1, 20)),
                          CFG_W'($urandom_range(1, 20)));
      endcase
      ni = eff_bins(src_bins_reg);
      no = eff_bins(dst_bins_reg);
      if ($urandom_range(0, 7) != 0) send_beat(OP_CLEAR, 0, 0, 0);
      n_acc = ni > 30 ? 30 : ni;
      for (int k = 0; k < n_acc; k++) begin
        send_beat(OP_ACC, pick_word(), pick_word(), CFG_W'($urandom));
        if ($urandom_range(0, 3) == 0)
          send_beat(OP_READ, 0, 0, CFG_W'($urandom_range(1, no)));
        if ($urandom_range(0, 24) == 0)
          send_beat(OP_NONE, $urandom, $urandom, CFG_W'($urandom));
      end
      if ($urandom_range(0, 3) == 0) send_beat(OP_ACC, pick_word(), pick_word(), 0);
      for (int b = 1; b <= no && b <= 24; b++) send_beat(OP_READ, 0, 0, b[CFG_W-1:0]);
      repeat ($urandom_range(0, 2)) begin
        rb = CFG_W'($urandom);
        send_beat(OP_READ, 0, 0, rb);
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    op_i        <= OP_ACC;
    content_i   <= '0;
    error_i     <= '0;
    read_bin_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_IN_BINS;
    cfg_wdata_i <= '0;
    src_bins_reg = 11'd1;
    dst_bins_reg = 11'd1;
    clear_sums();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_register_extremes();
    test_random_passes();

    drain();
    if (pending_reads.size() != 0) failed = 1;
    if (!failed) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
